// ===== src/concentric_square_to_disk_map_core_assert.svh =====
// Assertion macros for the disk-map RTL.
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_CORE_ASSERT_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSDM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/csdm_pkg.sv =====
// Shared types, constants and tables of the concentric disk mapper.
`timescale 1ns / 1ps
`default_nettype none
package csdm_pkg;

  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 16;
  localparam int FRAC     = 30;
  localparam int QUO_W    = FRAC + 1;
  localparam int CORD_W   = 34;

  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;
  localparam logic [29:0] INV_GAIN_Q30   = 30'd652032874;

  typedef enum logic [1:0] {
    SECT_0 = 2'd0,
    SECT_1 = 2'd1,
    SECT_2 = 2'd2,
    SECT_3 = 2'd3
  } sector_t;

  typedef struct packed {
    logic [IN_BITS-1:0] square_x;
    logic [IN_BITS-1:0] square_y;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] disk_x;
    logic signed [OUT_BITS-1:0] disk_y;
  } out_word_t;

  // Arctangent of 2^-i in radians, Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd843314857;
      1:  a = 32'd497837829;
      2:  a = 32'd263043837;
      3:  a = 32'd133525159;
      4:  a = 32'd67021687;
      5:  a = 32'd33543516;
      6:  a = 32'd16775851;
      7:  a = 32'd8388437;
      8:  a = 32'd4194283;
      9:  a = 32'd2097149;
      10: a = 32'd1048576;
      11: a = 32'd524288;
      12: a = 32'd262144;
      13: a = 32'd131072;
      14: a = 32'd65536;
      15: a = 32'd32768;
      16: a = 32'd16384;
      17: a = 32'd8192;
      18: a = 32'd4096;
      19: a = 32'd2048;
      20: a = 32'd1024;
      21: a = 32'd512;
      22: a = 32'd256;
      23: a = 32'd128;
      24: a = 32'd64;
      25: a = 32'd32;
      26: a = 32'd16;
      27: a = 32'd8;
      28: a = 32'd4;
      29: a = 32'd2;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/csdm_div_cell.sv =====
// One restoring-division cell: yields one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module csdm_div_cell #(
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 31,
  parameter int SIDE_W = 3,
  parameter bit FIRST  = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DEN_W-1:0]  in_rem,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [QUO_W-1:0]  in_quo,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [DEN_W-1:0]       out_rem,
  output logic [DEN_W-1:0]       out_den,
  output logic [QUO_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;
  logic [DEN_W-1:0] rem_next;

  // Double the remainder (not on the leading bit), trial-subtract the divisor
  always_comb begin
    trial    = FIRST ? {1'b0, in_rem} : {in_rem, 1'b0};
    take     = trial >= {1'b0, in_den};
    diff     = trial - {1'b0, in_den};
    rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance the word
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_den  <= in_den;
      out_quo  <= {in_quo[QUO_W-2:0], take};
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

// ===== src/csdm_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed shift and arctangent.
`timescale 1ns / 1ps
`default_nettype none
module csdm_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [csdm_pkg::CORD_W-1:0]  in_x,
  input  wire logic signed [csdm_pkg::CORD_W-1:0]  in_y,
  input  wire logic signed [csdm_pkg::CORD_W-1:0]  in_z,
  input  wire csdm_pkg::sector_t                   in_sect,
  output logic                                     out_valid,
  output logic signed [csdm_pkg::CORD_W-1:0]       out_x,
  output logic signed [csdm_pkg::CORD_W-1:0]       out_y,
  output logic signed [csdm_pkg::CORD_W-1:0]       out_z,
  output csdm_pkg::sector_t                        out_sect
);
  import csdm_pkg::*;

  localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(atan_q30(STEP));

  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;

  // Floor shifts of the cross terms
  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Rotate towards zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!in_z[CORD_W-1]) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end
      out_sect <= in_sect;
    end
  end

endmodule
`default_nettype wire

// ===== src/concentric_square_to_disk_map_core.sv =====
// Top level of the concentric square-to-disk mapper.
`timescale 1ns / 1ps
`default_nettype none
// Takes one sample word per cycle and returns one disk point word per cycle when not
// stalled, through one sector stage, 31 restoring-division cells for the Q30 ratio,
// split multiply and sum stages for angle and gain, ANGLE_STEPS (at most 32) CORDIC
// cells, and the output register. A one-word skid stage behind the output register
// takes one word when the output stalls; the sample side stalls only while that skid
// stage is full. No clearing pass after reset.
`include "concentric_square_to_disk_map_core_assert.svh"
module concentric_square_to_disk_map_core #(
  parameter int ANGLE_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire csdm_pkg::in_word_t  sample,
  output logic                     point_valid,
  input  wire logic                point_stall,
  output csdm_pkg::out_word_t      point
);
  import csdm_pkg::*;

  localparam int NSTEP   = (ANGLE_STEPS < 32) ? ANGLE_STEPS : 32;
  localparam int SW      = IN_BITS + 2;
  localparam int SIDE_W  = 3;
  localparam int RSH     = FRAC + 1 - IN_BITS;
  localparam int RSH_POS = (RSH >= 0) ? RSH : 0;
  localparam int OSH     = FRAC + 1 - OUT_BITS;
  localparam int RND_SH  = (OSH > 0) ? OSH : 0;
  localparam int UP_SH   = (OSH < 0) ? 1 : 0;
  localparam logic [SW-1:0] HALF = SW'(1) << (IN_BITS - 1);
  localparam logic signed [35:0] RND_ADD = (OSH > 0) ? (36'sd1 <<< (RND_SH - 1)) : 36'sd0;
  localparam logic signed [35:0] SAT_HI  = (36'sd1 <<< (OUT_BITS - 1)) - 36'sd1;
  localparam logic signed [35:0] SAT_LO  = -(36'sd1 <<< (OUT_BITS - 1));

  // Round half up and saturate a Q30 value to the output format
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] s;
    s = ((v + RND_ADD) >>> RND_SH) <<< UP_SH;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[OUT_BITS-1:0];
  endfunction

  logic en;

  // ---------------- sector stage ----------------
  logic signed [SW-1:0] sx, sy, nsx, nsy, rs, num;
  sector_t              sect;
  logic                 den_neg, neg;
  logic [SW-1:0]        nmag;

  always_comb begin
    sx  = $signed({2'b00, sample.square_x} - HALF);
    sy  = $signed({2'b00, sample.square_y} - HALF);
    nsx = -sx;
    nsy = -sy;
    if (sx > nsy) begin
      if (sx > sy) begin
        sect = SECT_0; rs = sx;  num = sy;
      end else begin
        sect = SECT_1; rs = sy;  num = nsx;
      end
    end else begin
      if (sx < sy) begin
        sect = SECT_2; rs = nsx; num = sy;
      end else begin
        sect = SECT_3; rs = nsy; num = nsx;
      end
    end
    unique case (sect)
      SECT_2:  den_neg = 1'b1;
      SECT_3:  den_neg = sy[SW-1];
      default: den_neg = 1'b0;
    endcase
    neg  = num[SW-1] ^ den_neg;
    nmag = num[SW-1] ? -num : num;
  end

  // ---------------- divider chain ----------------
  logic                 dv_valid [0:QUO_W];
  logic [IN_BITS-1:0]   dv_rem   [0:QUO_W];
  logic [IN_BITS-1:0]   dv_den   [0:QUO_W];
  logic [QUO_W-1:0]     dv_quo   [0:QUO_W];
  logic [SIDE_W-1:0]    dv_side  [0:QUO_W];

  // Hold valid of the sector stage under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sample_valid;
    end
  end

  // Register the sector, radius and ratio operands
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= nmag[IN_BITS-1:0];
      dv_den[0]  <= rs[IN_BITS-1:0];
      dv_quo[0]  <= '0;
      dv_side[0] <= {neg, sect};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    csdm_div_cell #(
      .DEN_W  (IN_BITS),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W),
      .FIRST  (k == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[k]),
      .in_rem    (dv_rem[k]),
      .in_den    (dv_den[k]),
      .in_quo    (dv_quo[k]),
      .in_side   (dv_side[k]),
      .out_valid (dv_valid[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_den   (dv_den[k+1]),
      .out_quo   (dv_quo[k+1]),
      .out_side  (dv_side[k+1])
    );
  end

  // ---------------- angle and gain multiplies ----------------
  logic [QUO_W-1:0] rq;
  logic [45:0]      ph_t, ph_r;
  logic [44:0]      pl_t, pl_r;
  logic             m1_valid, m1_neg;
  sector_t          m1_sect;
  logic [60:0]      sum_t, sum_r;

  // Move the radius to Q30
  always_comb begin
    if (RSH >= 0) begin
      rq = QUO_W'({{QUO_W{1'b0}}, dv_den[QUO_W]} << RSH_POS);
    end else begin
      rq = QUO_W'({{QUO_W{1'b0}}, dv_den[QUO_W]} >> 1);
    end
  end

  // Split both products into high and low partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ph_t    <= 46'(dv_quo[QUO_W][30:15]) * 46'(PI_QUARTER_Q30);
      pl_t    <= 45'(dv_quo[QUO_W][14:0]) * 45'(PI_QUARTER_Q30);
      ph_r    <= 46'(rq[30:15]) * 46'(INV_GAIN_Q30);
      pl_r    <= 45'(rq[14:0]) * 45'(INV_GAIN_Q30);
      m1_neg  <= dv_side[QUO_W][2];
      m1_sect <= sector_t'(dv_side[QUO_W][1:0]);
    end
  end

  always_comb begin
    sum_t = (61'(ph_t) << 15) + 61'(pl_t);
    sum_r = (61'(ph_r) << 15) + 61'(pl_r);
  end

  logic                     cv     [0:NSTEP];
  logic signed [CORD_W-1:0] cx     [0:NSTEP];
  logic signed [CORD_W-1:0] cy     [0:NSTEP];
  logic signed [CORD_W-1:0] cz     [0:NSTEP];
  sector_t                  csect  [0:NSTEP];

  // Hold valids of the multiply stages under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      cv[0]    <= 1'b0;
    end else if (en) begin
      m1_valid <= dv_valid[QUO_W];
      cv[0]    <= m1_valid;
    end
  end

  // Sum partial products and seed the rotation
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= $signed(CORD_W'(sum_r[59:30]));
      cy[0]    <= '0;
      cz[0]    <= m1_neg ? -$signed(CORD_W'(sum_t[59:30])) : $signed(CORD_W'(sum_t[59:30]));
      csect[0] <= m1_sect;
    end
  end

  // ---------------- CORDIC chain ----------------
  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    csdm_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_sect   (csect[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_sect  (csect[i+1])
    );
  end

  // ---------------- quarter turn and output ----------------
  logic signed [CORD_W-1:0] ox, oy;
  out_word_t                pd;
  logic                     pv;
  logic                     sv;
  out_word_t                sd;

  always_comb begin
    unique case (csect[NSTEP])
      SECT_0: begin ox = cx[NSTEP];  oy = cy[NSTEP];  end
      SECT_1: begin ox = -cy[NSTEP]; oy = cx[NSTEP];  end
      SECT_2: begin ox = -cx[NSTEP]; oy = -cy[NSTEP]; end
      default: begin ox = cy[NSTEP]; oy = -cx[NSTEP]; end
    endcase
    pd.disk_x = to_out(36'(ox));
    pd.disk_y = to_out(36'(oy));
    pv        = cv[NSTEP];
  end

  assign en           = !sv;
  assign sample_stall = sv;

  // Output register with one-word skid: drain skid first, park a word on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      sv          <= 1'b0;
    end else if (sv) begin
      if (!point_stall) begin
        point_valid <= 1'b1;
        sv          <= 1'b0;
      end
    end else if (!point_valid || !point_stall) begin
      point_valid <= pv;
    end else if (pv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (!point_stall) begin
        point <= sd;
      end
    end else if (!point_valid || !point_stall) begin
      point <= pd;
    end else if (pv) begin
      sd <= pd;
    end
  end

  `CSDM_ASSERT_NOW(a_skid_behind_out, clk, rst, sv, point_valid, "skid full with no output word")
  `CSDM_ASSERT_NEXT(a_skid_parks, clk, rst, !sv && pv && point_valid && point_stall, sv,
                    "stalled result not parked in skid")
  `CSDM_ASSERT_NEXT(a_skid_drains, clk, rst, sv && !point_stall, point == $past(sd),
                    "skid word not moved to output")

endmodule
`default_nettype wire

// ===== dv/concentric_square_to_disk_map_checker.sv =====
// Checker for the disk mapper: predicts each disk point and compares the returned words.
`timescale 1ns / 1ps
module concentric_square_to_disk_map_checker #(
  parameter int ANGLE_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                sample_stall,
  input  csdm_pkg::in_word_t  sample,
  input  logic                point_valid,
  input  logic                point_stall,
  input  csdm_pkg::out_word_t point,
  output int                  fail_count,
  output int                  pending_points,
  output int                  checked_points
);
  import csdm_pkg::*;

  localparam longint ANGLE_SCALE = 64'd843314857;
  localparam longint GAIN_SCALE  = 64'd652032874;

  out_word_t expected_points[$];

  // Arctangent of 2^-i in Q30
  function automatic longint arctan_step(input int i);
    longint steps[32];
    steps = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
              16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
              65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
              16, 8, 4, 2, 1, 0};
    return steps[i];
  endfunction

  // Q30 value rounded half up to the output format and saturated
  function automatic logic signed [OUT_BITS-1:0] round_to_point(input longint v);
    longint w;
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (OUT_BITS - 1));
    w = (v + (64'sd1 <<< (FRAC - OUT_BITS))) >>> (FRAC + 1 - OUT_BITS);
    if (w > hi) w = hi;
    if (w < lo) w = lo;
    return w[OUT_BITS-1:0];
  endfunction

  function automatic out_word_t map_to_disk(input in_word_t s);
    longint sx, sy, radius, num, den, ratio, angle, cx, cy, resid, dx, dy, mag;
    sector_t sect;
    out_word_t p;
    sx = longint'(s.square_x) - (64'sd1 <<< (IN_BITS - 1));
    sy = longint'(s.square_y) - (64'sd1 <<< (IN_BITS - 1));
    // pick the sector, radius and ratio terms
    if (sx > -sy) begin
      if (sx > sy) begin
        sect = SECT_0; radius = sx; num = sy; den = sx;
      end else begin
        sect = SECT_1; radius = sy; num = -sx; den = sy;
      end
    end else begin
      if (sx < sy) begin
        sect = SECT_2; radius = -sx; num = sy; den = sx;
      end else begin
        sect = SECT_3; radius = -sy; num = -sx; den = sy;
      end
    end
    // origin gives a zero ratio
    if (den == 0) begin
      ratio = 0;
    end else begin
      mag = ((num < 0 ? -num : num) <<< FRAC) / (den < 0 ? -den : den);
      ratio = ((num < 0) != (den < 0)) ? -mag : mag;
    end
    angle = ((ratio < 0 ? -ratio : ratio) * ANGLE_SCALE) >>> FRAC;
    if (ratio < 0) angle = -angle;
    radius = radius <<< (FRAC - (IN_BITS - 1));
    cx = (radius * GAIN_SCALE) >>> FRAC;
    cy = 0;
    resid = angle;
    // rotate through the residual angle
    for (int i = 0; i < ANGLE_STEPS && i < 32; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (resid >= 0) begin
        cx -= dx; cy += dy; resid -= arctan_step(i);
      end else begin
        cx += dx; cy -= dy; resid += arctan_step(i);
      end
    end
    // apply the quarter turn of the sector
    case (sect)
      SECT_0: begin p.disk_x = round_to_point(cx);  p.disk_y = round_to_point(cy);  end
      SECT_1: begin p.disk_x = round_to_point(-cy); p.disk_y = round_to_point(cx);  end
      SECT_2: begin p.disk_x = round_to_point(-cx); p.disk_y = round_to_point(-cy); end
      default: begin p.disk_x = round_to_point(cy); p.disk_y = round_to_point(-cx); end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked_points = 0;
  end

  assign pending_points = expected_points.size();

  // predict on accepted samples, compare accepted points
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (point_valid && !point_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point", point, 0);
        end else begin
          want = expected_points.pop_front();
          if (point.disk_x !== want.disk_x) report_mismatch("disk_x", point.disk_x, want.disk_x);
          if (point.disk_y !== want.disk_y) report_mismatch("disk_y", point.disk_y, want.disk_y);
          checked_points++;
        end
      end
      if (sample_valid && !sample_stall) expected_points = {expected_points, map_to_disk(sample)};
    end
  end
endmodule

// ===== dv/concentric_square_to_disk_map_core_test.sv =====
// Top of the disk mapper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module concentric_square_to_disk_map_core_test;
  import csdm_pkg::*;

  localparam int LATENCY = 35 + 16;

  logic      clk;
  logic      rst;
  logic      sample_valid;
  logic      sample_stall;
  in_word_t  sample;
  logic      point_valid;
  logic      point_stall;
  out_word_t point;
  int        fail_count;
  int        pending_points;
  int        checked_points;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off;

  concentric_square_to_disk_map_core DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .point_valid(point_valid), .point_stall(point_stall), .point(point)
  );

  concentric_square_to_disk_map_checker checker_i (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .fail_count(fail_count), .pending_points(pending_points),
    .checked_points(checked_points)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // offer one word, holding it until accepted; drop valid only while idling
  task automatic send_word(input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{square_x: x, square_y: y};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random point: mostly uniform, some on edges, diagonals and the centre
  task automatic send_random();
    logic [15:0] x, y;
    x = 16'($urandom);
    y = 16'($urandom);
    case ($urandom_range(9))
      0: x = y;
      1: x = 16'hFFFF - y;
      2: x = {$urandom_range(1) ? 16'hFFFF : 16'h0000};
      3: y = 16'(32'h8000 + $urandom_range(4) - 2);
      default: ;
    endcase
    send_word(x, y);
  endtask

  // receiver stall, with one long hold-off when asked
  always @(negedge clk) begin
    if (rst) point_stall <= 1'b0;
    else if (hold_off) point_stall <= 1'b1;
    else point_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    logic [15:0] corners[8];
    int timer;
    corners = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001, 16'h0001, 16'h5555,
                16'hAAAA};
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: origin, corners, edges, each sector and the positive limit
    send_word(16'h8000, 16'h8000);
    send_word(16'h8000, 16'h0000);
    for (int i = 0; i < 8; i += 2)
      for (int j = 1; j < 8; j += 3) send_word(corners[i], corners[j]);
    send_word(16'hC000, 16'h9000);
    send_word(16'h9000, 16'hC000);
    send_word(16'h3000, 16'h7000);
    send_word(16'h7000, 16'h3000);

    // random phases with different idling, long hold-off in the last
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 22 : 0;
      fork
        for (int n = 0; n < 130; n++) send_random();
        if (phase == 2) begin
          hold_off = 1;
          repeat (200) @(negedge clk);
          hold_off = 0;
        end
      join
    end
    sample_valid <= 1'b0;

    timer = 0;
    while (pending_points != 0 && timer < 10000) begin
      @(posedge clk);
      timer++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered origin, corners, sector borders and %0d random points", 390);
    $display("%0d points checked under mixed idling and a long output hold-off",
             checked_points);
    if (fail_count == 0 && pending_points == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
